### rtl/core/quadratic_root_solver_unit_defines.svh
// Assertion macros for the quadratic root solver checker.
// Each macro expects signals named clock and reset in the scope of use.
`ifndef QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_UNIT_DEFINES_SVH

// Same-cycle implication.
`define QRS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QRS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/qrs_pkg.sv
`timescale 1ns / 1ps

package qrs_pkg;

   localparam int SQRT_STAGES = 25;
   localparam int RAD_W       = 2 * SQRT_STAGES;
   localparam int REM_W       = SQRT_STAGES + 3;
   localparam int NUM_W       = 34;
   localparam int DEN_W       = 17;
   localparam int DREM_W      = DEN_W + 1;

   typedef enum logic [2:0] {
      KIND_NO_REAL  = 3'd0,
      KIND_LINEAR   = 3'd1,
      KIND_DOUBLE   = 3'd2,
      KIND_TWO      = 3'd3,
      KIND_INFINITE = 3'd4,
      KIND_NO_SOL   = 3'd5
   } kind_type;

   typedef struct packed {
      kind_type           kind;
      logic signed [15:0] a;
      logic signed [15:0] b;
      logic signed [15:0] c;
   } sq_meta_type;

   typedef struct packed {
      kind_type kind;
      logic     neg_first;
      logic     neg_second;
   } dv_meta_type;

endpackage

### rtl/core/quadratic_root_solver_unit.sv
// Quadratic root solver: real roots of a*x^2 + b*x + c, Q8.8 in, Q16.16 out.
// Pipeline: 64 register stages, from the coefficient capture to the output register.
// Throughput: one word per cycle, set by the fully pipelined root (25 stages)
// and divide (34 stages) units; a stall on rsp_ready holds the whole pipeline.
// Reset (synchronous, active high) clears every valid bit; data registers keep junk.
`timescale 1ns / 1ps

module quadratic_root_solver_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_coef_quad,
   input  logic signed [15:0] req_coef_lin,
   input  logic signed [15:0] req_coef_const,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_root_kind,
   output logic signed [31:0] rsp_root_first,
   output logic signed [31:0] rsp_root_second,
   output logic               rsp_saturated
);

   localparam logic signed [34:0] Q_MAX = 35'sd2147483647;
   localparam logic signed [34:0] Q_MIN = -35'sd2147483648;

   // Single pipeline enable: everything moves when the output register is free
   // or is being emptied this cycle. Bubbles travel like words.
   logic advance;
   logic rsp_valid_ff;
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // Stage 1: capture coefficients.
   logic               v1_ff;
   logic signed [15:0] a1_ff, b1_ff, c1_ff;

   // Stage 2: the two products of the discriminant.
   logic               v2_ff;
   logic signed [31:0] bb2_ff, ac2_ff, bb2_in, ac2_in;
   logic signed [15:0] a2_ff, b2_ff, c2_ff;

   // Stage 3: discriminant, classification, radicand D << 16.
   logic                       v3_ff;
   logic signed [34:0]         d3_calc;
   logic [qrs_pkg::RAD_W-1:0]  rad3_ff, rad3_in;
   qrs_pkg::sq_meta_type       meta3_ff, meta3_in;

   assign bb2_in  = b1_ff * b1_ff;
   assign ac2_in  = a1_ff * c1_ff;
   assign d3_calc = 35'(bb2_ff) - (35'(ac2_ff) <<< 2);

   always_comb begin
      meta3_in.a = a2_ff;
      meta3_in.b = b2_ff;
      meta3_in.c = c2_ff;
      if (a2_ff == 16'sd0) begin
         if (b2_ff != 16'sd0)      meta3_in.kind = qrs_pkg::KIND_LINEAR;
         else if (c2_ff == 16'sd0) meta3_in.kind = qrs_pkg::KIND_INFINITE;
         else                      meta3_in.kind = qrs_pkg::KIND_NO_SOL;
      end else if (d3_calc < 35'sd0) begin
         meta3_in.kind = qrs_pkg::KIND_NO_REAL;
      end else if (d3_calc == 35'sd0) begin
         meta3_in.kind = qrs_pkg::KIND_DOUBLE;
      end else begin
         meta3_in.kind = qrs_pkg::KIND_TWO;
      end
      // positive D stays below 2^33
      rad3_in = (d3_calc > 35'sd0) ? {1'b0, d3_calc[32:0], 16'b0} : '0;
   end

   // Square root pipeline.
   logic                             sq_valid;
   logic [qrs_pkg::SQRT_STAGES-1:0]  sq_root;
   qrs_pkg::sq_meta_type             sq_meta;

   qrs_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_valid (v3_ff),
      .in_rad   (rad3_ff),
      .in_meta  (meta3_ff),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_meta (sq_meta)
   );

   // Stage 4: signed numerators and divisor, split into magnitude and sign.
   logic signed [33:0]         n1_calc, n2_calc, nb_calc, s_calc;
   logic signed [15:0]         den_calc;
   logic [qrs_pkg::DEN_W-1:0]  den_mag;
   logic                       v4_ff;
   logic [qrs_pkg::NUM_W-1:0]  num1_ff, num1_in, num2_ff, num2_in;
   logic [qrs_pkg::DEN_W-1:0]  den4_ff;
   qrs_pkg::dv_meta_type       meta4_ff, meta4_in;

   always_comb begin
      nb_calc = -(34'(sq_meta.b)) <<< 8;
      s_calc  = $signed({9'b0, sq_root});
      n1_calc = '0;
      n2_calc = '0;
      den_calc = 16'sd1;
      case (sq_meta.kind)
         qrs_pkg::KIND_LINEAR: begin
            n1_calc  = -(34'(sq_meta.c)) <<< 16;
            den_calc = sq_meta.b;
         end
         qrs_pkg::KIND_DOUBLE: begin
            n1_calc  = -(34'(sq_meta.b)) <<< 15;
            den_calc = sq_meta.a;
         end
         qrs_pkg::KIND_TWO: begin
            n1_calc  = (nb_calc + s_calc) <<< 7;
            n2_calc  = (nb_calc - s_calc) <<< 7;
            den_calc = sq_meta.a;
         end
         default: begin
            n1_calc  = '0;
            n2_calc  = '0;
            den_calc = 16'sd1;
         end
      endcase
      den_mag = den_calc[15] ? 17'(-(17'(den_calc))) : 17'(den_calc);
      // magnitudes stay below 2^33, so negation cannot overflow
      num1_in = n1_calc[33] ? 34'(-n1_calc) : 34'(n1_calc);
      num2_in = n2_calc[33] ? 34'(-n2_calc) : 34'(n2_calc);
      meta4_in.kind       = sq_meta.kind;
      meta4_in.neg_first  = n1_calc[33] ^ den_calc[15];
      meta4_in.neg_second = n2_calc[33] ^ den_calc[15];
   end

   // Divider pipeline.
   logic                       dv_valid;
   logic [qrs_pkg::NUM_W-1:0]  q1, q2;
   qrs_pkg::dv_meta_type       dv_meta;

   qrs_div u_div (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (v4_ff),
      .in_num_first   (num1_ff),
      .in_num_second  (num2_ff),
      .in_den         (den4_ff),
      .in_meta        (meta4_ff),
      .out_valid      (dv_valid),
      .out_quot_first (q1),
      .out_quot_second(q2),
      .out_meta       (dv_meta)
   );

   // Output stage: restore sign, clip to Q16.16, mask unreported roots.
   logic signed [34:0] r1_full, r2_full;
   logic signed [31:0] r1_clip, r2_clip;
   logic               sat1, sat2, rep1, rep2;
   logic [2:0]         kind_ff, kind_in;
   logic signed [31:0] first_ff, first_in, second_ff, second_in;
   logic               sat_ff, sat_in;

   always_comb begin
      r1_full = dv_meta.neg_first  ? -$signed({1'b0, q1}) : $signed({1'b0, q1});
      r2_full = dv_meta.neg_second ? -$signed({1'b0, q2}) : $signed({1'b0, q2});
      sat1 = (r1_full > Q_MAX) || (r1_full < Q_MIN);
      sat2 = (r2_full > Q_MAX) || (r2_full < Q_MIN);
      if (r1_full > Q_MAX)      r1_clip = Q_MAX[31:0];
      else if (r1_full < Q_MIN) r1_clip = Q_MIN[31:0];
      else                      r1_clip = r1_full[31:0];
      if (r2_full > Q_MAX)      r2_clip = Q_MAX[31:0];
      else if (r2_full < Q_MIN) r2_clip = Q_MIN[31:0];
      else                      r2_clip = r2_full[31:0];
      rep1 = (dv_meta.kind == qrs_pkg::KIND_LINEAR) ||
             (dv_meta.kind == qrs_pkg::KIND_DOUBLE) ||
             (dv_meta.kind == qrs_pkg::KIND_TWO);
      rep2 = (dv_meta.kind == qrs_pkg::KIND_TWO);
      kind_in   = dv_meta.kind;
      first_in  = rep1 ? r1_clip : 32'sd0;
      second_in = rep2 ? r2_clip : 32'sd0;
      sat_in    = (rep1 && sat1) || (rep2 && sat2);
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= sq_valid;
         rsp_valid_ff <= dv_valid;
      end
   end

   // Data registers.
   always_ff @(posedge clock) begin
      if (advance) begin
         a1_ff     <= req_coef_quad;
         b1_ff     <= req_coef_lin;
         c1_ff     <= req_coef_const;
         bb2_ff    <= bb2_in;
         ac2_ff    <= ac2_in;
         a2_ff     <= a1_ff;
         b2_ff     <= b1_ff;
         c2_ff     <= c1_ff;
         rad3_ff   <= rad3_in;
         meta3_ff  <= meta3_in;
         num1_ff   <= num1_in;
         num2_ff   <= num2_in;
         den4_ff   <= den_mag;
         meta4_ff  <= meta4_in;
         kind_ff   <= kind_in;
         first_ff  <= first_in;
         second_ff <= second_in;
         sat_ff    <= sat_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_root_kind   = kind_ff;
   assign rsp_root_first  = first_ff;
   assign rsp_root_second = second_ff;
   assign rsp_saturated   = sat_ff;

endmodule

### rtl/core/qrs_sqrt.sv
`timescale 1ns / 1ps

// Floor square root, one result bit per stage.
module qrs_sqrt (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  in_valid,
   input  logic [qrs_pkg::RAD_W-1:0]             in_rad,
   input  qrs_pkg::sq_meta_type                  in_meta,
   output logic                                  out_valid,
   output logic [qrs_pkg::SQRT_STAGES-1:0]       out_root,
   output qrs_pkg::sq_meta_type                  out_meta
);

   localparam int N = qrs_pkg::SQRT_STAGES;

   logic [N-1:0]                    valid_ff;
   logic [qrs_pkg::RAD_W-1:0]       rad_ff  [N];
   logic [qrs_pkg::RAD_W-1:0]       rad_in  [N];
   logic [qrs_pkg::REM_W-1:0]       rem_ff  [N];
   logic [qrs_pkg::REM_W-1:0]       rem_in  [N];
   logic [N-1:0]                    root_ff [N];
   logic [N-1:0]                    root_in [N];
   qrs_pkg::sq_meta_type            meta_ff [N];

   always_comb begin : step
      logic [qrs_pkg::RAD_W-1:0] p_rad;
      logic [qrs_pkg::REM_W-1:0] p_rem;
      logic [N-1:0]              p_root;
      logic [qrs_pkg::REM_W-1:0] shifted;
      logic [qrs_pkg::REM_W-1:0] trial;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            p_rad  = in_rad;
            p_rem  = '0;
            p_root = '0;
         end else begin
            p_rad  = rad_ff[i-1];
            p_rem  = rem_ff[i-1];
            p_root = root_ff[i-1];
         end
         shifted = {p_rem[qrs_pkg::REM_W-3:0], p_rad[qrs_pkg::RAD_W-1 -: 2]};
         trial   = {1'b0, p_root, 2'b01};
         if (shifted >= trial) begin
            rem_in[i]  = shifted - trial;
            root_in[i] = {p_root[N-2:0], 1'b1};
         end else begin
            rem_in[i]  = shifted;
            root_in[i] = {p_root[N-2:0], 1'b0};
         end
         rad_in[i] = {p_rad[qrs_pkg::RAD_W-3:0], 2'b00};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < N; i++) begin
            rad_ff[i]  <= rad_in[i];
            rem_ff[i]  <= rem_in[i];
            root_ff[i] <= root_in[i];
            meta_ff[i] <= (i == 0) ? in_meta : meta_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign out_valid = valid_ff[N-1];
   assign out_root  = root_ff[N-1];
   assign out_meta  = meta_ff[N-1];

endmodule

### rtl/core/qrs_div.sv
`timescale 1ns / 1ps

// Two-lane unsigned restoring divider, one quotient bit per stage.
// Both lanes share the divisor.
module qrs_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  logic                          in_valid,
   input  logic [qrs_pkg::NUM_W-1:0]     in_num_first,
   input  logic [qrs_pkg::NUM_W-1:0]     in_num_second,
   input  logic [qrs_pkg::DEN_W-1:0]     in_den,
   input  qrs_pkg::dv_meta_type          in_meta,
   output logic                          out_valid,
   output logic [qrs_pkg::NUM_W-1:0]     out_quot_first,
   output logic [qrs_pkg::NUM_W-1:0]     out_quot_second,
   output qrs_pkg::dv_meta_type          out_meta
);

   localparam int N = qrs_pkg::NUM_W;
   localparam int R = qrs_pkg::DREM_W;

   logic [N-1:0]                  valid_ff;
   logic [N-1:0]                  num_ff  [2][N];
   logic [N-1:0]                  num_in  [2][N];
   logic [R-1:0]                  rem_ff  [2][N];
   logic [R-1:0]                  rem_in  [2][N];
   logic [qrs_pkg::DEN_W-1:0]     den_ff  [N];
   qrs_pkg::dv_meta_type          meta_ff [N];

   always_comb begin : step
      logic [N-1:0]              p_num;
      logic [R-1:0]              p_rem;
      logic [qrs_pkg::DEN_W-1:0] p_den;
      logic [R-1:0]              shifted;
      logic                      ge;
      for (int l = 0; l < 2; l++) begin
         for (int i = 0; i < N; i++) begin
            if (i == 0) begin
               p_num = (l == 0) ? in_num_first : in_num_second;
               p_rem = '0;
               p_den = in_den;
            end else begin
               p_num = num_ff[l][i-1];
               p_rem = rem_ff[l][i-1];
               p_den = den_ff[i-1];
            end
            shifted = {p_rem[R-2:0], p_num[N-1]};
            ge      = shifted >= {1'b0, p_den};
            rem_in[l][i] = ge ? shifted - {1'b0, p_den} : shifted;
            num_in[l][i] = {p_num[N-2:0], ge};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (advance) begin
         valid_ff <= {valid_ff[N-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < N; i++) begin
            for (int l = 0; l < 2; l++) begin
               num_ff[l][i] <= num_in[l][i];
               rem_ff[l][i] <= rem_in[l][i];
            end
            den_ff[i]  <= (i == 0) ? in_den  : den_ff[(i == 0) ? 0 : i-1];
            meta_ff[i] <= (i == 0) ? in_meta : meta_ff[(i == 0) ? 0 : i-1];
         end
      end
   end

   assign out_valid       = valid_ff[N-1];
   assign out_quot_first  = num_ff[0][N-1];
   assign out_quot_second = num_ff[1][N-1];
   assign out_meta        = meta_ff[N-1];

endmodule

### rtl/core/qrs_checker.sv
`timescale 1ns / 1ps
`include "quadratic_root_solver_unit_defines.svh"

module qrs_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_root_kind,
   input logic signed [31:0] rsp_root_first,
   input logic signed [31:0] rsp_root_second,
   input logic               rsp_saturated
);

   logic two_roots;
   logic no_root;
   logic root_clear;

   assign two_roots  = (rsp_root_kind == qrs_pkg::KIND_TWO);
   assign no_root    = (rsp_root_kind == qrs_pkg::KIND_NO_REAL) ||
                       (rsp_root_kind == qrs_pkg::KIND_INFINITE) ||
                       (rsp_root_kind == qrs_pkg::KIND_NO_SOL);
   assign root_clear = (rsp_root_first == 32'sd0) && !rsp_saturated;

   `QRS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "rsp word dropped")
   `QRS_ASSERT_NOW(a_stall_back, rsp_valid && !rsp_ready, !req_ready, "req taken under stall")
   `QRS_ASSERT_NOW(a_second_zero, rsp_valid && !two_roots, rsp_root_second == 32'sd0, "second root")
   `QRS_ASSERT_NOW(a_no_root, rsp_valid && no_root, root_clear, "root reported without a root")
   `QRS_ASSERT_NOW(a_reset_clear, $past(reset), !rsp_valid, "rsp valid after reset")

endmodule

bind quadratic_root_solver_unit qrs_checker u_qrs_checker (.*);

### sim/tb_quadratic_root_solver_unit.sv
`timescale 1ns / 1ps

module tb_quadratic_root_solver_unit;

   // one coefficient set as offered on the request side
   typedef struct {
      logic signed [15:0] qa;
      logic signed [15:0] qb;
      logic signed [15:0] qc;
   } coef_set_type;

   // roots as the block should report them
   typedef struct {
      qrs_pkg::kind_type  kind;
      logic signed [31:0] first;
      logic signed [31:0] second;
      logic               sat;
   } root_set_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic signed [15:0] req_coef_quad = '0;
   logic signed [15:0] req_coef_lin = '0;
   logic signed [15:0] req_coef_const = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_root_kind;
   logic signed [31:0] rsp_root_first;
   logic signed [31:0] rsp_root_second;
   logic               rsp_saturated;

   coef_set_type coef_queue[$];  // words still to be offered
   root_set_type roots_due[$];   // predicted results, oldest first
   bit        quiet = 1'b0;      // no idling in the closing stretch
   bit        failed = 1'b0;
   int        send_gap = 0;
   int        recv_gap = 0;
   int        roots_seen = 0;
   bit        long_hold_done = 1'b0;

   quadratic_root_solver_unit i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_coef_quad   (req_coef_quad),
      .req_coef_lin    (req_coef_lin),
      .req_coef_const  (req_coef_const),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_root_kind   (rsp_root_kind),
      .rsp_root_first  (rsp_root_first),
      .rsp_root_second (rsp_root_second),
      .rsp_saturated   (rsp_saturated)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // floor square root, one result bit per pass
   function automatic longint floor_sqrt(input longint unsigned n);
      longint unsigned rem;
      longint unsigned res;
      longint unsigned bt;
      rem = n;
      res = 0;
      bt  = 64'd1 << 62;
      while (bt > rem) bt = bt >> 2;
      while (bt != 0) begin
         if (rem >= res + bt) begin
            rem = rem - (res + bt);
            res = (res >> 1) + bt;
         end else begin
            res = res >> 1;
         end
         bt = bt >> 2;
      end
      return longint'(res);
   endfunction

   // clip to the Q16.16 range, noting any clipping
   function automatic logic signed [31:0] clip_q16(input longint v, inout logic sat);
      if (v > 64'sd2147483647) begin
         sat = 1'b1;
         return 32'sh7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         sat = 1'b1;
         return 32'sh8000_0000;
      end
      return v[31:0];
   endfunction

   // classify and solve one coefficient set; SV division truncates toward zero
   function automatic root_set_type solve_roots(input coef_set_type cs);
      root_set_type r;
      longint    a, b, c, disc, s, nb;
      a = cs.qa;
      b = cs.qb;
      c = cs.qc;
      r.first  = '0;
      r.second = '0;
      r.sat    = 1'b0;
      if (a == 0) begin
         if (b != 0) begin
            r.kind  = qrs_pkg::KIND_LINEAR;
            r.first = clip_q16((-c * 65536) / b, r.sat);
         end else begin
            r.kind = (c == 0) ? qrs_pkg::KIND_INFINITE : qrs_pkg::KIND_NO_SOL;
         end
      end else begin
         disc = b * b - 4 * a * c;
         if (disc < 0) begin
            r.kind = qrs_pkg::KIND_NO_REAL;
         end else if (disc == 0) begin
            r.kind  = qrs_pkg::KIND_DOUBLE;
            r.first = clip_q16((-b * 32768) / a, r.sat);
         end else begin
            s        = floor_sqrt(longint'(disc) << 16);
            nb       = -b * 256;
            r.kind   = qrs_pkg::KIND_TWO;
            r.first  = clip_q16(((nb + s) * 128) / a, r.sat);
            r.second = clip_q16(((nb - s) * 128) / a, r.sat);
         end
      end
      return r;
   endfunction

   function automatic coef_set_type make_coefs(input int qa, input int qb, input int qc);
      coef_set_type cs;
      cs.qa = qa[15:0];
      cs.qb = qb[15:0];
      cs.qc = qc[15:0];
      return cs;
   endfunction

   // random set, biased towards the interesting classes
   function automatic coef_set_type random_coefs();
      coef_set_type cs;
      int        k, r;
      cs.qa = 16'($urandom);
      cs.qb = 16'($urandom);
      cs.qc = 16'($urandom);
      case ($urandom_range(0, 9))
         0: cs.qa = '0;                                  // linear
         1: begin                                        // degenerate
            cs.qa = '0;
            cs.qb = '0;
            if ($urandom_range(0, 1)) cs.qc = '0;
         end
         2: begin                                        // exact double root
            k = $urandom_range(1, 40);
            r = $urandom_range(0, 40) - 20;
            if ($urandom_range(0, 1)) k = -k;
            cs = make_coefs(k, -2 * k * r, k * r * r);
         end
         3: begin                                        // small a, big roots
            cs.qa = 16'($urandom_range(0, 7) - 3);
         end
         4: begin                                        // small magnitudes
            cs = make_coefs($urandom_range(0, 1023) - 512, $urandom_range(0, 1023) - 512,
                            $urandom_range(0, 1023) - 512);
         end
         default: ;
      endcase
      return cs;
   endfunction

   // driver: offer the next word, hold it until taken, insert idle bursts
   always @(posedge clock) begin
      coef_set_type cs;
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && req_ready) begin
            cs.qa = req_coef_quad;
            cs.qb = req_coef_lin;
            cs.qc = req_coef_const;
            roots_due.push_back(solve_roots(cs));
         end
         if (!(req_valid && !req_ready)) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (coef_queue.size() == 0) begin
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
               send_gap  <= $urandom_range(0, 6);
               req_valid <= 1'b0;
            end else begin
               cs = coef_queue.pop_front();
               req_valid      <= 1'b1;
               req_coef_quad  <= cs.qa;
               req_coef_lin   <= cs.qb;
               req_coef_const <= cs.qc;
            end
         end
      end
   end

   // monitor: check each taken word, stall at random, one long hold-off
   always @(posedge clock) begin
      root_set_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap  <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            roots_seen = roots_seen + 1;
            if (roots_due.size() == 0) begin
               $display("%0t: unexpected word kind %0d first %0d second %0d sat %0d",
                        $time, rsp_root_kind, rsp_root_first, rsp_root_second,
                        rsp_saturated);
               failed = 1'b1;
            end else begin
               want = roots_due.pop_front();
               if (rsp_root_kind !== want.kind) begin
                  $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                           rsp_root_kind);
                  failed = 1'b1;
               end
               if (rsp_root_first !== want.first) begin
                  $display("%0t: first root expected %0d actual %0d", $time,
                           want.first, rsp_root_first);
                  failed = 1'b1;
               end
               if (rsp_root_second !== want.second) begin
                  $display("%0t: second root expected %0d actual %0d", $time,
                           want.second, rsp_root_second);
                  failed = 1'b1;
               end
               if (rsp_saturated !== want.sat) begin
                  $display("%0t: saturated expected %0d actual %0d", $time,
                           want.sat, rsp_saturated);
                  failed = 1'b1;
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap  <= recv_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && roots_seen >= 120) begin
            // long hold-off so the pipeline fills and backs up the input
            long_hold_done = 1'b1;
            recv_gap  <= 299;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 4) == 0) begin
            recv_gap  <= $urandom_range(0, 6);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every kind, saturation
      coef_queue.push_back(make_coefs(0, 0, 0));              // infinite
      coef_queue.push_back(make_coefs(0, 0, 256));            // no solution
      coef_queue.push_back(make_coefs(0, 0, -32768));
      coef_queue.push_back(make_coefs(0, 256, -512));         // linear, x = 2
      coef_queue.push_back(make_coefs(0, 1, 32767));          // linear, x = -32767
      coef_queue.push_back(make_coefs(0, -1, -32768));
      coef_queue.push_back(make_coefs(0, -32768, 32767));
      coef_queue.push_back(make_coefs(256, 0, 256));          // no real root
      coef_queue.push_back(make_coefs(256, -512, 256));       // double, x = 1
      coef_queue.push_back(make_coefs(1, 32767, 0));          // two, big root
      coef_queue.push_back(make_coefs(256, 0, -1024));        // two, x = +-2
      coef_queue.push_back(make_coefs(-32768, -32768, -32768));
      coef_queue.push_back(make_coefs(32767, 32767, 32767));
      coef_queue.push_back(make_coefs(-32768, 32767, 32767));
      coef_queue.push_back(make_coefs(32767, -32768, -32768));
      coef_queue.push_back(make_coefs(1, -32768, -32768));
      coef_queue.push_back(make_coefs(-1, 32767, 32767));
      coef_queue.push_back(make_coefs(1, 2, 1));              // double, tiny a
      coef_queue.push_back(make_coefs(-1, 0, 0));             // double at zero
      coef_queue.push_back(make_coefs(1, -32768, 0));
      coef_queue.push_back(make_coefs(-32768, 0, 0));

      // sender pauses until every result is back
      wait (coef_queue.size() == 0 && !req_valid && roots_due.size() == 0);

      repeat (390) coef_queue.push_back(random_coefs());
      wait (coef_queue.size() == 0);
      quiet = 1'b1;
      repeat (60) coef_queue.push_back(random_coefs());

      wait (coef_queue.size() == 0 && !req_valid && roots_due.size() == 0);
      repeat (100) @(posedge clock);
      if (!failed) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

endmodule
